### rtl/pksg_pkg.sv
// types and constants shared by the port knocking source gate
`default_nettype none

package pksg_pkg;

  // field widths
  localparam int unsigned PROTO_W = 8;
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned CFG_IDX_W = 8;

  // default sizing of the authorized-source table
  localparam int unsigned PKSG_TABLE_ENTRIES = 8192;
  localparam int unsigned PKSG_PROBE_LIMIT   = 4;

  // ip protocol numbers
  localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
  localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KNOCK_PORT   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GUARDED_PORT = 8'd1;

  // register reset values
  localparam logic [PORT_W-1:0] KNOCK_PORT_RST   = 16'd1111;
  localparam logic [PORT_W-1:0] GUARDED_PORT_RST = 16'd6666;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_CHECK,
    ST_DONE
  } pksg_state_e;

endpackage

`default_nettype wire

### rtl/pksg_if.sv
// valid/ready channels of the port knocking source gate
`default_nettype none

interface pksg_pkt_if;
  logic                          valid;
  logic                          ready;
  logic [pksg_pkg::PROTO_W-1:0]  protocol;
  logic [pksg_pkg::PORT_W-1:0]   dest_port;
  logic [pksg_pkg::ADDR_W-1:0]   source_addr;

  modport source (output valid, output protocol, output dest_port, output source_addr,
                  input ready);
  modport sink   (input valid, input protocol, input dest_port, input source_addr,
                  output ready);
endinterface

interface pksg_res_if;
  logic valid;
  logic ready;
  logic verdict;
  logic insert_failed;

  modport source (output valid, output verdict, output insert_failed, input ready);
  modport sink   (input valid, input verdict, input insert_failed, output ready);
endinterface

interface pksg_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pksg_pkg::CFG_IDX_W-1:0] index;
  logic [pksg_pkg::PORT_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/pksg_ram.sv
// generic single-write single-read ram with registered read data
`default_nettype none

module pksg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/port_knock_source_gate.sv
// port knocking gate: knock table, probe sequencer and result register
`default_nettype none

// Port knocking gate over parsed packet headers. A UDP transfer to knock_port records
// the source address in a table of authorized sources (XOR-fold hash of the address,
// then a linear probe of up to PROBE_LIMIT slots); when the probe window holds no free
// slot the address is not recorded and insert_failed is set. A TCP transfer to
// guarded_port gets verdict 1 (drop) unless its source is in the table; every other
// packet passes with verdict 0. Exactly one result per packet, in order. The table
// lives in one RAM with a registered read, so probes run one slot per cycle; a packet
// that needs no lookup goes straight to the result, a lookup first reduces the fold to
// its home slot (a reciprocal multiply for the quotient, then a multiply-subtract for
// the remainder, only when TABLE_ENTRIES is not a power of two) and then probes. The
// block works on one packet at a time; a finished result sits in an output register
// so the next packet is taken while it waits. After reset the table is swept clear,
// one entry per cycle; no packet is taken during the sweep, configuration writes are.
// Entries are never removed.
module port_knock_source_gate #(
  parameter int unsigned TABLE_ENTRIES = pksg_pkg::PKSG_TABLE_ENTRIES,
  parameter int unsigned PROBE_LIMIT   = pksg_pkg::PKSG_PROBE_LIMIT
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pksg_pkt_if.sink    pkt_i,
  pksg_res_if.source  res_o,
  pksg_cfg_if.sink    cfg_i
);

  localparam int unsigned IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int unsigned PRB_W   = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
  localparam int unsigned ADDR_W  = pksg_pkg::ADDR_W;
  localparam int unsigned PORT_W  = pksg_pkg::PORT_W;
  localparam int unsigned WORD_W  = ADDR_W + 1;
  localparam bit          IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
  // ceil(2^(16+IDX_W) / TABLE_ENTRIES) gives the exact quotient for every 16-bit fold
  localparam int unsigned     RECIP_SH   = 16 + IDX_W;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << RECIP_SH) + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES);
  localparam logic [16:0]     RECIP      = 17'(RECIP_FULL);
  localparam logic [15:0]     ENTRIES16  = 16'(TABLE_ENTRIES);

  localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [PRB_W-1:0]  LAST_PROBE = PRB_W'(PROBE_LIMIT - 1);

  pksg_pkg::pksg_state_e state_q, state_d;

  // table sweep and probe control
  logic [IDX_W-1:0]  clr_q, clr_d;
  logic [IDX_W-1:0]  slot_q, slot_d;
  logic [PRB_W-1:0]  probe_q, probe_d;
  logic [15:0]       rem_q, rem_d;
  logic [15:0]       quot_q, quot_d;
  logic              mod_step_q, mod_step_d;

  // packet under lookup
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic              knock_item_q, knock_item_d;

  // pending result and output register
  logic res_verdict_q, res_verdict_d;
  logic res_failed_q, res_failed_d;
  logic out_valid_q, out_valid_d;
  logic out_verdict_q, out_verdict_d;
  logic out_failed_q, out_failed_d;

  // configuration registers
  logic [PORT_W-1:0] knock_port_q, knock_port_d;
  logic [PORT_W-1:0] guarded_port_q, guarded_port_d;

  // table ram port
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  // helpers
  logic              pkt_xfer;
  logic              is_knock;
  logic              is_guard;
  logic [15:0]       fold;
  logic [32:0]       recip_prod;
  logic [15:0]       quot_mul;
  logic [15:0]       rem_next;
  logic              entry_valid;
  logic              entry_hit;
  logic              out_free;
  logic [IDX_W-1:0]  slot_next;
  logic              check_end;

  pksg_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // packet classification at the input
  assign pkt_xfer = pkt_i.valid && pkt_i.ready;
  assign is_knock = (pkt_i.protocol == pksg_pkg::PROTO_UDP) && (pkt_i.dest_port == knock_port_q);
  assign is_guard = (pkt_i.protocol == pksg_pkg::PROTO_TCP)
                    && (pkt_i.dest_port == guarded_port_q);
  assign fold     = pkt_i.source_addr[31:16] ^ pkt_i.source_addr[15:0];

  // fold mod TABLE_ENTRIES: quotient by reciprocal, then fold minus quotient times entries
  assign recip_prod = 33'(rem_q) * 33'(RECIP);
  assign quot_mul   = quot_q * ENTRIES16;
  assign rem_next   = rem_q - quot_mul;

  // probe compare on the word read last cycle
  assign entry_valid = ram_rdata[ADDR_W];
  assign entry_hit   = entry_valid && (ram_rdata[ADDR_W-1:0] == addr_q);
  assign slot_next   = (slot_q == LAST_IDX) ? '0 : slot_q + 1'b1;
  assign check_end   = !entry_valid || entry_hit || (probe_q == LAST_PROBE);

  assign out_free = !out_valid_q || res_o.ready;

  // channel handshakes
  assign pkt_i.ready = (state_q == pksg_pkg::ST_IDLE);
  assign cfg_i.ready = 1'b1;

  assign res_o.valid         = out_valid_q;
  assign res_o.verdict       = out_verdict_q;
  assign res_o.insert_failed = out_failed_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pksg_pkg::ST_CLEAR: begin
        if (clr_q == LAST_IDX) begin
          state_d = pksg_pkg::ST_IDLE;
        end
      end
      pksg_pkg::ST_IDLE: begin
        if (pkt_xfer) begin
          if (is_knock || is_guard) begin
            state_d = IS_POW2 ? pksg_pkg::ST_CHECK : pksg_pkg::ST_MOD;
          end else begin
            state_d = pksg_pkg::ST_DONE;
          end
        end
      end
      pksg_pkg::ST_MOD: begin
        if (!mod_step_q) begin
          state_d = pksg_pkg::ST_CHECK;
        end
      end
      pksg_pkg::ST_CHECK: begin
        if (check_end) begin
          state_d = pksg_pkg::ST_DONE;
        end
      end
      pksg_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = pksg_pkg::ST_IDLE;
        end
      end
      default: state_d = pksg_pkg::ST_CLEAR;
    endcase
  end

  // datapath and ram control
  always_comb begin
    clr_d         = clr_q;
    slot_d        = slot_q;
    probe_d       = probe_q;
    rem_d         = rem_q;
    quot_d        = quot_q;
    mod_step_d    = mod_step_q;
    addr_d        = addr_q;
    knock_item_d  = knock_item_q;
    res_verdict_d = res_verdict_q;
    res_failed_d  = res_failed_q;
    out_valid_d   = out_valid_q;
    out_verdict_d = out_verdict_q;
    out_failed_d  = out_failed_q;
    ram_we        = 1'b0;
    ram_waddr     = slot_q;
    ram_wdata     = {1'b1, addr_q};
    ram_re        = 1'b0;
    ram_raddr     = slot_q;

    // result taken downstream
    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      pksg_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
      end
      pksg_pkg::ST_IDLE: begin
        if (pkt_xfer) begin
          addr_d        = pkt_i.source_addr;
          knock_item_d  = is_knock;
          rem_d         = fold;
          mod_step_d    = 1'b1;
          probe_d       = '0;
          res_verdict_d = 1'b0;
          res_failed_d  = 1'b0;
          // power-of-two table: the home slot is the low bits of the fold
          if (IS_POW2 && (is_knock || is_guard)) begin
            slot_d    = fold[IDX_W-1:0];
            ram_re    = 1'b1;
            ram_raddr = fold[IDX_W-1:0];
          end
        end
      end
      pksg_pkg::ST_MOD: begin
        if (mod_step_q) begin
          // first step: quotient
          quot_d     = 16'(recip_prod >> RECIP_SH);
          mod_step_d = 1'b0;
        end else begin
          // second step: remainder is the home slot
          slot_d    = rem_next[IDX_W-1:0];
          ram_re    = 1'b1;
          ram_raddr = rem_next[IDX_W-1:0];
        end
      end
      pksg_pkg::ST_CHECK: begin
        if (!entry_valid) begin
          // first free slot: a knock claims it, a guarded packet is unknown
          if (knock_item_q) begin
            ram_we = 1'b1;
          end else begin
            res_verdict_d = 1'b1;
          end
        end else if (entry_hit) begin
          res_verdict_d = 1'b0;
        end else if (probe_q == LAST_PROBE) begin
          // probe window full
          if (knock_item_q) begin
            res_failed_d = 1'b1;
          end else begin
            res_verdict_d = 1'b1;
          end
        end else begin
          slot_d    = slot_next;
          probe_d   = probe_q + 1'b1;
          ram_re    = 1'b1;
          ram_raddr = slot_next;
        end
      end
      pksg_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_verdict_d = res_verdict_q;
          out_failed_d  = res_failed_q;
        end
      end
      default: begin
        clr_d = '0;
      end
    endcase
  end

  // configuration writes, unknown indexes ignored
  always_comb begin
    knock_port_d   = knock_port_q;
    guarded_port_d = guarded_port_q;
    if (cfg_i.valid && cfg_i.ready) begin
      if (cfg_i.index == pksg_pkg::REG_KNOCK_PORT) begin
        knock_port_d = cfg_i.data;
      end else if (cfg_i.index == pksg_pkg::REG_GUARDED_PORT) begin
        guarded_port_d = cfg_i.data;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= pksg_pkg::ST_CLEAR;
      clr_q          <= '0;
      probe_q        <= '0;
      mod_step_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      knock_port_q   <= pksg_pkg::KNOCK_PORT_RST;
      guarded_port_q <= pksg_pkg::GUARDED_PORT_RST;
    end else begin
      state_q        <= state_d;
      clr_q          <= clr_d;
      probe_q        <= probe_d;
      mod_step_q     <= mod_step_d;
      out_valid_q    <= out_valid_d;
      knock_port_q   <= knock_port_d;
      guarded_port_q <= guarded_port_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    slot_q        <= slot_d;
    rem_q         <= rem_d;
    quot_q        <= quot_d;
    addr_q        <= addr_d;
    knock_item_q  <= knock_item_d;
    res_verdict_q <= res_verdict_d;
    res_failed_q  <= res_failed_d;
    out_verdict_q <= out_verdict_d;
    out_failed_q  <= out_failed_d;
  end

  // table write and read never share a cycle
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("table write and read in the same cycle");

  // a probe write only fills a free slot for a knock
  a_insert_free_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && (state_q == pksg_pkg::ST_CHECK)) |-> (knock_item_q && !entry_valid))
    else $error("table insert into an occupied slot or for a non-knock packet");

  // a waiting result leaves only when taken
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_o.ready) |=> out_valid_q)
    else $error("pending result dropped before transfer");

endmodule

`default_nettype wire
